### rtl/core/dual_encoder_velocity_averager_defines.svh
// Assertion macros for the dual encoder velocity averager.
// Included by the top level only; no other dependencies.
`ifndef DUAL_ENCODER_VELOCITY_AVERAGER_DEFINES_SVH
`define DUAL_ENCODER_VELOCITY_AVERAGER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define DEVAVG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("devavg: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define DEVAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("devavg: next-cycle check failed");
`else
`define DEVAVG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DEVAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/devavg_pkg.sv
// Shared constants, defaults and control structs of the velocity averager.
// No dependencies; used by every module of the block.
`default_nettype none

package devavg_pkg;

    // Field widths and positions of the encoder word.
    localparam int WORD_W   = 20;
    localparam int POS_W    = 9;
    localparam int PAN_LSB  = 2;
    localparam int TILT_LSB = 11;

    // Result field widths.
    localparam int TICKS_W = 12;
    localparam int VEL_W   = 28;

    // Scale register.
    localparam int SCALE_W = 16;
    localparam logic [SCALE_W-1:0] VELOCITY_SCALE_RESET = 16'd4575;

    // Parameter defaults.
    localparam int WINDOW_LEN_DEF     = 10;
    localparam int COUNTS_PER_REV_DEF = 360;

    // Ring memory access strobes.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ring_ctrl_t;

    // Load strobes of the scaling pipeline.
    typedef struct packed {
        logic load_a;
        logic load_b;
    } scale_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/devavg_reduce.sv
// Reduces a 9-bit absolute count modulo one revolution.
// Uses devavg_pkg for the count width.
`default_nettype none

module devavg_reduce #(
    parameter int COUNTS_PER_REV = devavg_pkg::COUNTS_PER_REV_DEF
) (
    input  logic [devavg_pkg::POS_W-1:0] count,
    output logic [devavg_pkg::POS_W-1:0] position
);

    localparam int POS_W       = devavg_pkg::POS_W;
    localparam int RECIP_SHIFT = 2 * POS_W;
    localparam int RECIP       = (1 << RECIP_SHIFT) / COUNTS_PER_REV;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = POS_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    logic [PROD_W-1:0]  recip_prod;
    logic [QUOT_W-1:0]  quot;
    logic [2*POS_W-1:0] quot_times_rev;
    logic [POS_W:0]     rem;

    // The reciprocal estimate of the quotient is exact or one low.
    assign recip_prod     = PROD_W'(count) * PROD_W'(RECIP);
    assign quot           = recip_prod[PROD_W-1:RECIP_SHIFT];
    assign quot_times_rev = (2*POS_W)'(quot) * (2*POS_W)'(COUNTS_PER_REV);
    assign rem            = (POS_W+1)'(count) - (POS_W+1)'(quot_times_rev);

    // One correcting subtraction brings the remainder below a revolution.
    always_comb
    begin
        if (rem >= (POS_W+1)'(COUNTS_PER_REV))
        begin
            position = POS_W'(rem - (POS_W+1)'(COUNTS_PER_REV));
        end
        else
        begin
            position = POS_W'(rem);
        end
    end

endmodule

`default_nettype wire

### rtl/core/devavg_ring.sv
// Step ring memory for both channels, with per-entry valid bits and slot pointers.
// Uses devavg_pkg for the access strobe struct.
`default_nettype none

module devavg_ring #(
    parameter int WINDOW_LEN = devavg_pkg::WINDOW_LEN_DEF,
    parameter int DATA_W     = 18
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  devavg_pkg::ring_ctrl_t ctrl,
    input  logic [DATA_W-1:0]      wr_data,
    output logic [DATA_W-1:0]      rd_data
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

    logic [DATA_W-1:0]     mem [WINDOW_LEN];
    logic [DATA_W-1:0]     rd_data_reg;
    logic                  rd_hit_reg;
    logic [WINDOW_LEN-1:0] valid_reg;
    logic [SLOT_W-1:0]     rd_slot_reg;
    logic [SLOT_W-1:0]     rd_slot_next;
    logic [SLOT_W-1:0]     wr_slot_reg;

    // The read slot steps round the ring once per word.
    always_comb
    begin
        if (rd_slot_reg == LAST_SLOT)
        begin
            rd_slot_next = '0;
        end
        else
        begin
            rd_slot_next = rd_slot_reg + 1'b1;
        end
    end

    // Slot pointers and valid bits. The write of a word always uses the slot
    // its own read used, and the next read is always to the following slot,
    // so a read never meets a write to the same entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_slot_reg <= '0;
            wr_slot_reg <= '0;
            rd_hit_reg  <= 1'b0;
            valid_reg   <= '0;
        end
        else
        begin
            if (ctrl.rd_en)
            begin
                rd_slot_reg <= rd_slot_next;
                wr_slot_reg <= rd_slot_reg;
                rd_hit_reg  <= valid_reg[rd_slot_reg];
            end
            if (ctrl.wr_en)
            begin
                valid_reg[wr_slot_reg] <= 1'b1;
            end
        end
    end

    // Memory array with registered read data.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_slot_reg] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_slot_reg];
        end
    end

    // An entry never written since reset reads as a zero step.
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### rtl/core/devavg_scale.sv
// Velocity scaling and output saturation, two register stages.
// Uses devavg_pkg for field widths and the load strobe struct.
`default_nettype none

module devavg_scale #(
    parameter int SUM_W = 12
) (
    input  logic                                clk,
    input  devavg_pkg::scale_ctrl_t             ctrl,
    input  logic signed [SUM_W-1:0]             pan_sum,
    input  logic signed [SUM_W-1:0]             tilt_sum,
    input  logic [devavg_pkg::SCALE_W-1:0]      scale,
    output logic signed [devavg_pkg::TICKS_W-1:0] pan_window_ticks,
    output logic signed [devavg_pkg::TICKS_W-1:0] tilt_window_ticks,
    output logic signed [devavg_pkg::VEL_W-1:0]   pan_velocity,
    output logic signed [devavg_pkg::VEL_W-1:0]   tilt_velocity
);

    localparam int TICKS_W = devavg_pkg::TICKS_W;
    localparam int VEL_W   = devavg_pkg::VEL_W;
    localparam int PROD_W  = SUM_W + devavg_pkg::SCALE_W + 1;
    localparam int TEXT_W  = (SUM_W > TICKS_W) ? SUM_W : TICKS_W;
    localparam int VEXT_W  = (PROD_W > VEL_W) ? PROD_W : VEL_W;

    localparam logic signed [TICKS_W-1:0] TICKS_MAX = {1'b0, {(TICKS_W-1){1'b1}}};
    localparam logic signed [TICKS_W-1:0] TICKS_MIN = {1'b1, {(TICKS_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0]   VEL_MAX   = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0]   VEL_MIN   = {1'b1, {(VEL_W-1){1'b0}}};

    logic signed [PROD_W-1:0]  pan_prod_reg;
    logic signed [PROD_W-1:0]  tilt_prod_reg;
    logic signed [TICKS_W-1:0] pan_ticks_reg;
    logic signed [TICKS_W-1:0] tilt_ticks_reg;
    logic signed [PROD_W-1:0]  scale_s;

    function automatic logic signed [TICKS_W-1:0] sat_ticks(input logic signed [SUM_W-1:0] s);
        logic signed [TEXT_W-1:0] ext;
        logic signed [TICKS_W-1:0] res;
        ext = TEXT_W'(s);
        if (ext > TEXT_W'(TICKS_MAX))
        begin
            res = TICKS_MAX;
        end
        else if (ext < TEXT_W'(TICKS_MIN))
        begin
            res = TICKS_MIN;
        end
        else
        begin
            res = TICKS_W'(ext);
        end
        return res;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [PROD_W-1:0] p);
        logic signed [VEXT_W-1:0] ext;
        logic signed [VEL_W-1:0] res;
        ext = VEXT_W'(p);
        if (ext > VEXT_W'(VEL_MAX))
        begin
            res = VEL_MAX;
        end
        else if (ext < VEXT_W'(VEL_MIN))
        begin
            res = VEL_MIN;
        end
        else
        begin
            res = VEL_W'(ext);
        end
        return res;
    endfunction

    // The scale is unsigned, so it enters the product with a zero sign bit.
    assign scale_s = PROD_W'($signed({1'b0, scale}));

    // First stage: products and saturated tick sums.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            pan_prod_reg   <= PROD_W'(pan_sum) * scale_s;
            tilt_prod_reg  <= PROD_W'(tilt_sum) * scale_s;
            pan_ticks_reg  <= sat_ticks(pan_sum);
            tilt_ticks_reg <= sat_ticks(tilt_sum);
        end
    end

    // Second stage: saturated velocities into the output registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_b)
        begin
            pan_velocity      <= sat_vel(pan_prod_reg);
            tilt_velocity     <= sat_vel(tilt_prod_reg);
            pan_window_ticks  <= pan_ticks_reg;
            tilt_window_ticks <= tilt_ticks_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/core/dual_encoder_velocity_averager.sv
// Top level of the dual encoder velocity averager.
// Depends on devavg_pkg, devavg_reduce, devavg_ring, devavg_scale and the defines header.
`default_nettype none
`include "dual_encoder_velocity_averager_defines.svh"

// Takes one encoder word per cycle while in_stall is low and returns one result
// word per input word. The pipeline runs as: accept and ring read (the ring
// memory has registered read data), step and running sum update with ring
// write, multiply by velocity_scale, then saturation into the output register.
// A stall on the output backs up through the stages, and input words are still
// taken while any stage has room. The step ring needs no clearing pass after
// reset: each entry has a valid bit and reads as zero until first written.
// velocity_scale must only be written while no word is in flight.
module dual_encoder_velocity_averager #(
    parameter int WINDOW_LEN     = devavg_pkg::WINDOW_LEN_DEF,
    parameter int COUNTS_PER_REV = devavg_pkg::COUNTS_PER_REV_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [devavg_pkg::WORD_W-1:0]         encoder_word,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [devavg_pkg::TICKS_W-1:0] pan_window_ticks,
    output logic signed [devavg_pkg::TICKS_W-1:0] tilt_window_ticks,
    output logic signed [devavg_pkg::VEL_W-1:0]   pan_velocity,
    output logic signed [devavg_pkg::VEL_W-1:0]   tilt_velocity,
    input  logic                                  scale_wr_en,
    input  logic [devavg_pkg::SCALE_W-1:0]        scale_wr_data
);

    localparam int POS_W  = devavg_pkg::POS_W;
    localparam int STEP_W = $clog2(COUNTS_PER_REV / 2 + 1) + 1;
    localparam int SUM_W  = $clog2(WINDOW_LEN * (COUNTS_PER_REV / 2) + 1) + 1;

    localparam logic signed [POS_W+1:0] REV_S  = (POS_W+2)'(COUNTS_PER_REV);
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(WINDOW_LEN * (COUNTS_PER_REV / 2));
    localparam logic signed [SUM_W-1:0] SUM_LO =
        SUM_W'(-(WINDOW_LEN * ((COUNTS_PER_REV - 1) / 2)));

    logic [devavg_pkg::SCALE_W-1:0] velocity_scale_reg;

    logic [POS_W-1:0] pan_pos;
    logic [POS_W-1:0] tilt_pos;
    logic [POS_W-1:0] pan_pos_reg;
    logic [POS_W-1:0] tilt_pos_reg;
    logic [POS_W-1:0] pan_last_reg;
    logic [POS_W-1:0] tilt_last_reg;

    logic signed [STEP_W-1:0] pan_step;
    logic signed [STEP_W-1:0] tilt_step;
    logic signed [STEP_W-1:0] pan_old;
    logic signed [STEP_W-1:0] tilt_old;
    logic [2*STEP_W-1:0]      ring_rd_data;

    logic signed [SUM_W-1:0] pan_sum_reg;
    logic signed [SUM_W-1:0] tilt_sum_reg;
    logic signed [SUM_W-1:0] pan_sum_next;
    logic signed [SUM_W-1:0] tilt_sum_next;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
    logic accept;
    logic load_sum;

    devavg_pkg::ring_ctrl_t  ring_ctrl;
    devavg_pkg::scale_ctrl_t scale_ctrl;

    // Wrapped step in (-half, +half] revolution; exactly half counts as positive.
    function automatic logic signed [STEP_W-1:0] wrap_step(
        input logic [POS_W-1:0] last,
        input logic [POS_W-1:0] cur
    );
        logic signed [POS_W+1:0] d;
        d = $signed({2'b00, cur}) - $signed({2'b00, last});
        if (d < 0)
        begin
            d = d + REV_S;
        end
        if ((d <<< 1) > REV_S)
        begin
            d = d - REV_S;
        end
        return STEP_W'(d);
    endfunction

    // Scale register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_scale_reg <= devavg_pkg::VELOCITY_SCALE_RESET;
        end
        else if (scale_wr_en)
        begin
            velocity_scale_reg <= scale_wr_data;
        end
    end

    // Pipeline flow control: a stage moves when the one after it has room.
    assign s4_en    = !s4_valid_reg || !out_stall;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;
    assign accept   = in_valid && s1_en;
    assign load_sum = s1_valid_reg && s2_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign out_valid = s4_valid_reg;

    // Position reduction of both channels at acceptance.
    devavg_reduce #(
        .COUNTS_PER_REV(COUNTS_PER_REV)
    ) u_pan_reduce (
        .count   (encoder_word[devavg_pkg::PAN_LSB +: POS_W]),
        .position(pan_pos)
    );

    devavg_reduce #(
        .COUNTS_PER_REV(COUNTS_PER_REV)
    ) u_tilt_reduce (
        .count   (encoder_word[devavg_pkg::TILT_LSB +: POS_W]),
        .position(tilt_pos)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pan_pos_reg  <= pan_pos;
            tilt_pos_reg <= tilt_pos;
        end
    end

    // Step ring: read the oldest step at acceptance, replace it one stage later.
    assign ring_ctrl.rd_en = accept;
    assign ring_ctrl.wr_en = load_sum;

    devavg_ring #(
        .WINDOW_LEN(WINDOW_LEN),
        .DATA_W    (2 * STEP_W)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ring_ctrl),
        .wr_data({tilt_step, pan_step}),
        .rd_data(ring_rd_data)
    );

    // Steps and running sums of the word in the first stage.
    assign pan_step      = wrap_step(pan_last_reg, pan_pos_reg);
    assign tilt_step     = wrap_step(tilt_last_reg, tilt_pos_reg);
    assign pan_old       = $signed(ring_rd_data[STEP_W-1:0]);
    assign tilt_old      = $signed(ring_rd_data[2*STEP_W-1:STEP_W]);
    assign pan_sum_next  = pan_sum_reg + SUM_W'(pan_step) - SUM_W'(pan_old);
    assign tilt_sum_next = tilt_sum_reg + SUM_W'(tilt_step) - SUM_W'(tilt_old);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_last_reg  <= '0;
            tilt_last_reg <= '0;
            pan_sum_reg   <= '0;
            tilt_sum_reg  <= '0;
        end
        else if (load_sum)
        begin
            pan_last_reg  <= pan_pos_reg;
            tilt_last_reg <= tilt_pos_reg;
            pan_sum_reg   <= pan_sum_next;
            tilt_sum_reg  <= tilt_sum_next;
        end
    end

    // Scaling and saturation into the output word.
    assign scale_ctrl.load_a = s2_valid_reg && s3_en;
    assign scale_ctrl.load_b = s3_valid_reg && s4_en;

    devavg_scale #(
        .SUM_W(SUM_W)
    ) u_scale (
        .clk              (clk),
        .ctrl             (scale_ctrl),
        .pan_sum          (pan_sum_reg),
        .tilt_sum         (tilt_sum_reg),
        .scale            (velocity_scale_reg),
        .pan_window_ticks (pan_window_ticks),
        .tilt_window_ticks(tilt_window_ticks),
        .pan_velocity     (pan_velocity),
        .tilt_velocity    (tilt_velocity)
    );

    // The input is only held off while the first stage is occupied.
    `DEVAVG_ASSERT_IMPL(a_stall_needs_full, clk, rst_n, in_stall, s1_valid_reg)
    // An accepted word always occupies the first stage on the next cycle.
    `DEVAVG_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, accept, s1_valid_reg)
    // A running sum over the ring can never leave the window bounds.
    `DEVAVG_ASSERT_IMPL(a_sum_in_window, clk, rst_n, 1'b1,
        (pan_sum_reg <= SUM_HI) && (pan_sum_reg >= SUM_LO) &&
        (tilt_sum_reg <= SUM_HI) && (tilt_sum_reg >= SUM_LO))

endmodule

`default_nettype wire
